>>> design/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_SURR     = 3'd4;

  // Job queue between decoder and unit builder
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);

  // Code point limits
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

  // Lead byte class boundaries
  localparam logic [7:0] LEAD_ASCII_END = 8'h80;
  localparam logic [7:0] LEAD_2_START   = 8'hC2;
  localparam logic [7:0] LEAD_3_START   = 8'hE0;
  localparam logic [7:0] LEAD_4_START   = 8'hF0;
  localparam logic [7:0] LEAD_BAD_START = 8'hF5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [2:0]  status;
    logic        last_of_run;
  } out_item_t;

  // One decoded event: a code point or an error status
  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  status;
  } job_t;

endpackage

>>> design/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Byte decoder: classifies lead bytes, gathers continuation bits and emits
// one job per finished code point or error.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  u8u16_pkg::in_item_t  item,
  output logic                 job_valid,
  output u8u16_pkg::job_t      job
);

  logic [14:0] partial;
  logic [14:0] partial_next;
  logic [1:0]  remaining;
  logic [1:0]  remaining_next;
  logic [20:0] joined;
  logic [1:0]  rem_dec;
  logic [7:0]  b;
  logic        eos;

  assign b       = item.in_byte;
  assign eos     = item.end_of_string;
  assign joined  = {partial, b[5:0]};
  assign rem_dec = remaining - 2'd1;

  always_comb begin
    partial_next   = partial;
    remaining_next = remaining;
    job_valid      = 1'b0;
    job.cp         = 21'd0;
    job.status     = u8u16_pkg::ST_OK;
    if (remaining == 2'd0) begin
      priority if (b < u8u16_pkg::LEAD_ASCII_END) begin
        job_valid = 1'b1;
        job.cp    = {13'd0, b};
      end else if (b < u8u16_pkg::LEAD_2_START || b >= u8u16_pkg::LEAD_BAD_START) begin
        job_valid  = 1'b1;
        job.status = u8u16_pkg::ST_BAD_LEAD;
      end else begin
        priority if (b < u8u16_pkg::LEAD_3_START) begin
          partial_next   = {10'd0, b[4:0]};
          remaining_next = 2'd1;
        end else if (b < u8u16_pkg::LEAD_4_START) begin
          partial_next   = {11'd0, b[3:0]};
          remaining_next = 2'd2;
        end else begin
          partial_next   = {12'd0, b[2:0]};
          remaining_next = 2'd3;
        end
        if (eos) begin
          // lead byte ends the string: drop the sequence
          partial_next   = 15'd0;
          remaining_next = 2'd0;
          job_valid      = 1'b1;
          job.status     = u8u16_pkg::ST_TRUNC;
        end
      end
    end else if (rem_dec != 2'd0) begin
      partial_next   = joined[14:0];
      remaining_next = rem_dec;
      if (eos) begin
        partial_next   = 15'd0;
        remaining_next = 2'd0;
        job_valid      = 1'b1;
        job.status     = u8u16_pkg::ST_TRUNC;
      end
    end else begin
      partial_next   = 15'd0;
      remaining_next = 2'd0;
      job_valid      = 1'b1;
      job.cp         = joined;
      priority if (joined > u8u16_pkg::CP_MAX) begin
        job.status = u8u16_pkg::ST_RANGE;
      end else if (joined >= u8u16_pkg::CP_SURR_LO && joined <= u8u16_pkg::CP_SURR_HI) begin
        job.status = u8u16_pkg::ST_SURR;
      end else begin
        job.status = u8u16_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial   <= 15'd0;
      remaining <= 2'd0;
    end else if (accept) begin
      partial   <= partial_next;
      remaining <= remaining_next;
    end
  end

endmodule

>>> design/u8u16_jobq.sv
// ----------------------------------------------------------------------------
// u8u16_jobq
// Short FIFO of decoded jobs between the decoder and the unit builder.
// ----------------------------------------------------------------------------
module u8u16_jobq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  u8u16_pkg::job_t  wr_job,
  output logic             full,
  input  logic             rd,
  output logic             rd_valid,
  output u8u16_pkg::job_t  rd_job
);

  localparam logic [u8u16_pkg::JQ_AW:0] DEPTH = (u8u16_pkg::JQ_AW + 1)'(u8u16_pkg::JQ_DEPTH);

  u8u16_pkg::job_t              slots [u8u16_pkg::JQ_DEPTH];
  logic [u8u16_pkg::JQ_AW-1:0]  wr_ptr;
  logic [u8u16_pkg::JQ_AW-1:0]  rd_ptr;
  logic [u8u16_pkg::JQ_AW:0]    count;
  logic                         do_wr;
  logic                         do_rd;

  assign full     = (count == DEPTH);
  assign rd_valid = (count != '0);
  assign rd_job   = slots[rd_ptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Unit builder: turns jobs into UTF-16 words, splitting supplementary code
// points into surrogate pairs, and holds the word for the consumer.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  input  u8u16_pkg::job_t       job,
  output logic                  job_take,
  output logic                  empty,
  input  logic                  pop,
  output u8u16_pkg::out_item_t  result
);

  logic                  out_valid;
  u8u16_pkg::out_item_t  out_word;
  u8u16_pkg::out_item_t  word_next;
  logic                  phase;
  logic                  load;
  logic                  is_pair;
  logic [20:0]           offset;

  assign empty   = !out_valid;
  assign result  = out_word;
  assign load    = job_valid && (!out_valid || pop);
  assign is_pair = (job.status == u8u16_pkg::ST_OK) && (job.cp[20:16] != 5'd0);
  assign offset  = job.cp - u8u16_pkg::CP_SUPP_BASE;
  // hold the job until its low surrogate is loaded into the output register
  assign job_take = load && !(is_pair && !phase);

  always_comb begin
    word_next.status      = job.status;
    word_next.last_of_run = 1'b1;
    word_next.code_unit   = job.cp[15:0];
    if (job.status != u8u16_pkg::ST_OK) begin
      word_next.code_unit = 16'd0;
    end else if (is_pair && !phase) begin
      word_next.code_unit   = u8u16_pkg::HI_SURR_BASE | {6'd0, offset[19:10]};
      word_next.last_of_run = 1'b0;
    end else if (is_pair) begin
      word_next.code_unit = u8u16_pkg::LO_SURR_BASE | {6'd0, job.cp[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= is_pair && !phase;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_phase_holds_job: assert property (@(posedge clk) disable iff (rst)
    phase |-> job_valid && job.status == u8u16_pkg::ST_OK && job.cp[20:16] != 5'd0)
    else $error("second half of a pair pending without its job");

  a_phase_high_shown: assert property (@(posedge clk) disable iff (rst)
    phase |-> out_valid && !out_word.last_of_run)
    else $error("pair pending but high surrogate not on the output");

  a_not_last_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.last_of_run) |-> out_word.status == u8u16_pkg::ST_OK)
    else $error("error word flagged as not last of run");

  a_low_follows_high: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pop && !out_word.last_of_run) |=>
      (out_valid && out_word.last_of_run && out_word.code_unit[15:10] == 6'b110111))
    else $error("high surrogate not followed by low surrogate");

endmodule

>>> design/utf8_to_utf16_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// UTF-8 byte stream in, UTF-16 code units with status out.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per cycle while full is low. The decoder state is
// updated in the same cycle, and each finished code point or error becomes
// one job in a four-entry job queue; full rises only when the queue is full.
// The output register sends one word per cycle while pop is held and jobs
// are waiting. A surrogate pair gives two words but comes from four bytes,
// so with pop held the queue never backs up and input runs at one byte per
// cycle. Only a stalled pop fills the queue and stops input. The first word
// for a byte is on the result ports after the queue write and then the
// output register load; it comes later when older words are still waiting
// ahead of it.
// Errors (bad lead, truncated, above range, surrogate) give one word with
// code unit zero and return the decoder to idle.
module utf8_to_utf16_transcoder_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  u8u16_pkg::in_item_t   item,
  output logic                  empty,
  input  logic                  pop,
  output u8u16_pkg::out_item_t  result
);

  logic             accept;
  logic             job_valid;
  u8u16_pkg::job_t  job;
  logic             q_valid;
  u8u16_pkg::job_t  q_job;
  logic             q_take;

  assign accept = push && !full;

  u8u16_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .job_valid (job_valid),
    .job       (job)
  );

  u8u16_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .wr       (accept && job_valid),
    .wr_job   (job),
    .full     (full),
    .rd       (q_take),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_job),
    .job_take  (q_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
